@@ rtl/core/running_sample_statistics_top_defines.svh @@
`ifndef RUNNING_SAMPLE_STATISTICS_TOP_DEFINES_SVH
`define RUNNING_SAMPLE_STATISTICS_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, masked in reset
`define RSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, masked in reset
`define RSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rss_pkg.sv @@
package rss_pkg;

  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned VALUE_BITS      = SAMPLE_BITS - 1;
  localparam int unsigned COUNT_OUT_BITS  = 16;
  localparam int unsigned FRAC_BITS       = 8;
  localparam int unsigned MEAN_BITS       = VALUE_BITS + FRAC_BITS;
  localparam int unsigned MAX_COUNT_DEF   = 65535;
  localparam logic [VALUE_BITS-1:0] MIN_RESET = '1;

  // result word, sample_count in the lowest bits
  typedef struct packed {
    logic [4:0]                pad;
    logic [VALUE_BITS-1:0]     spread;
    logic [MEAN_BITS-1:0]      mean_q8;
    logic [VALUE_BITS-1:0]     smallest;
    logic [VALUE_BITS-1:0]     second_largest;
    logic [VALUE_BITS-1:0]     largest;
    logic [COUNT_OUT_BITS-1:0] sample_count;
  } result_t;

  // result flags, empty_run in bit 0
  typedef struct packed {
    logic count_overflow;
    logic empty_run;
  } flags_t;

  localparam int unsigned M_TDATA_W = $bits(result_t);
  localparam int unsigned M_TUSER_W = $bits(flags_t);

endpackage

@@ rtl/core/rss_div.sv @@
module rss_div #(
  parameter int unsigned CW = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [CW+rss_pkg::VALUE_BITS-1:0]      sum,
  input  logic [CW-1:0]                          divisor,
  output logic                                   done,
  output logic [rss_pkg::MEAN_BITS-1:0]          quotient
);
  import rss_pkg::*;

  localparam int unsigned CNT_W = $clog2(MEAN_BITS);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [CW-1:0]     rem;
  logic [MEAN_BITS-1:0] shreg;
  logic [CW:0]       trial;
  logic              ge;

  // one restoring step per cycle
  assign trial = {rem, shreg[MEAN_BITS-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MEAN_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= sum[CW+VALUE_BITS-1:VALUE_BITS];
      shreg <= {sum[VALUE_BITS-1:0], FRAC_BITS'(0)};
    end else if (busy) begin
      rem   <= ge ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
      shreg <= {shreg[MEAN_BITS-2:0], ge};
    end
  end

  assign quotient = shreg;

endmodule

@@ rtl/core/running_sample_statistics_top.sv @@
// running sample statistics
// s_tvalid/s_tready/s_tdata: one signed 16-bit sample per word. a positive
// sample is folded into the running count, sum, largest, second largest and
// smallest in the cycle it is accepted, so samples stream at one per cycle while
// s_tready is high. a sample of zero or below closes the run and produces one
// result word on m_tvalid/m_tready/m_tdata/m_tuser: count, largest, second
// largest, smallest, mean (8 fraction bits) and spread, with empty_run and
// count_overflow flags in m_tuser.
// a closing sample of a non-empty run starts a restoring divider, one quotient
// bit per cycle, and waits in ST_DIV until it is done, then in ST_LOAD until the
// output register is free; an empty run goes straight to ST_LOAD. s_tready is low
// from the closing sample until the result is in the output register.
// the output register holds its word while m_tready is low; new samples are
// still taken then; s_tready stays low after a closing sample until its word loads.
// once the count reaches MAX_COUNT further samples are dropped and
// count_overflow is reported with the run.
// rst (synchronous) clears the run state and drops any pending result.
module running_sample_statistics_top #(
  parameter int unsigned MAX_COUNT = rss_pkg::MAX_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rss_pkg::SAMPLE_BITS-1:0] s_tdata,  // sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // sample_count, largest, second_largest, smallest, mean_q8, spread, zero pad
  output logic [rss_pkg::M_TDATA_W-1:0]  m_tdata,
  // empty_run, count_overflow
  output logic [rss_pkg::M_TUSER_W-1:0]  m_tuser
);
  import rss_pkg::*;

  localparam int unsigned CW = $clog2(MAX_COUNT + 1);
  localparam int unsigned SW = CW + VALUE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t state, state_next;

  logic [SW-1:0]         running_sum;
  logic [CW-1:0]         running_count;
  logic [VALUE_BITS-1:0] max_value;
  logic [VALUE_BITS-1:0] second_max_value;
  logic [VALUE_BITS-1:0] min_value;
  logic                  overflow_seen;

  logic                  accept;
  logic                  positive;
  logic                  saturated;
  logic                  is_empty;
  logic                  out_free;
  logic                  load;
  logic                  div_start;
  logic                  div_done;
  logic [MEAN_BITS-1:0]  div_quotient;
  logic [VALUE_BITS-1:0] raw;
  result_t               result;
  flags_t                flags;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign raw       = s_tdata[VALUE_BITS-1:0];
  assign positive  = !s_tdata[SAMPLE_BITS-1] && (raw != '0);
  assign saturated = running_count >= CW'(MAX_COUNT);
  assign is_empty  = running_count == '0;
  assign out_free  = !m_tvalid || m_tready;
  assign load      = (state == ST_LOAD) && out_free;
  assign div_start = accept && !positive && !is_empty;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !positive) begin
          state_next = is_empty ? ST_LOAD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load) begin
      running_sum      <= '0;
      running_count    <= '0;
      max_value        <= '0;
      second_max_value <= '0;
      min_value        <= MIN_RESET;
      overflow_seen    <= 1'b0;
    end else if (accept && positive) begin
      if (saturated) begin
        overflow_seen <= 1'b1;
      end else begin
        running_sum   <= running_sum + SW'(raw);
        running_count <= running_count + 1'b1;
        if (max_value < raw) begin
          second_max_value <= max_value;
          max_value        <= raw;
        end else if (second_max_value < raw) begin
          second_max_value <= raw;
        end
        if (min_value > raw) begin
          min_value <= raw;
        end
      end
    end
  end

  rss_div #(
    .CW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sum      (running_sum),
    .divisor  (running_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    result                = '0;
    result.sample_count   = COUNT_OUT_BITS'(running_count);
    flags.empty_run       = is_empty;
    flags.count_overflow  = overflow_seen;
    if (!is_empty) begin
      result.largest        = max_value;
      result.second_largest = second_max_value;
      result.smallest       = min_value;
      result.mean_q8        = div_quotient;
      result.spread         = max_value - min_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= result;
      m_tuser <= flags;
    end
  end

endmodule

@@ rtl/core/rss_checker.sv @@
`include "running_sample_statistics_top_defines.svh"

module rss_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [rss_pkg::SAMPLE_BITS-1:0] s_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rss_pkg::M_TDATA_W-1:0]   m_tdata,
  input logic [rss_pkg::M_TUSER_W-1:0]   m_tuser
);
  import rss_pkg::*;

  result_t r;
  flags_t  f;
  logic    closing;

  assign r       = m_tdata;
  assign f       = m_tuser;
  assign closing = s_tvalid && s_tready &&
                   (s_tdata[SAMPLE_BITS-1] || (s_tdata == '0));

  `RSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")
  `RSS_ASSERT_NEXT(a_close_stalls, closing, !s_tready, "input still ready after closing sample")
  `RSS_ASSERT_NOW(a_empty_zero, m_tvalid && f.empty_run, r.sample_count == '0 && r.largest == '0 && r.smallest == '0 && r.mean_q8 == '0 && r.spread == '0, "empty run with nonzero fields")
  `RSS_ASSERT_NOW(a_order, m_tvalid && !f.empty_run, r.largest >= r.second_largest && r.largest >= r.smallest && r.spread == r.largest - r.smallest && r.sample_count != '0, "inconsistent statistics")

endmodule

bind running_sample_statistics_top rss_checker u_rss_checker (.*);

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rss_pkg::*;

  localparam int unsigned MAX_SAMPLES = MAX_COUNT_DEF;
  localparam int unsigned RANDOM_WORDS = 1050;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    flags_t  flags;
    result_t stats;
  } due_t;

  typedef struct packed {
    logic [15:0]          sample;
    int unsigned          reps;
    bit                   typed;
    logic [15:0]          cnt;
    logic [VALUE_BITS-1:0] lg;
    logic [VALUE_BITS-1:0] sec;
    logic [VALUE_BITS-1:0] sm;
    logic [MEAN_BITS-1:0] mean;
    logic [VALUE_BITS-1:0] spr;
    bit                   emp;
    bit                   ovf;
  } stim_row_t;

  typedef enum int {PACE_OPEN, PACE_COIN, PACE_SPARSE, PACE_RHYTHM} pace_t;

  // directed words; typed rows carry the expected result of their closing word
  localparam int NUM_ROWS = 22;
  localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
    '{16'h0000, 32'd1, 1'b1, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b1, 1'b0},
    '{16'h8000, 32'd1, 1'b1, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b1, 1'b0},
    '{16'hFFFF, 32'd1, 1'b1, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b1, 1'b0},
    '{16'h7FFF, 32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'h0000, 32'd1, 1'b1, 16'd1, 15'd32767, 15'd0, 15'd32767, 23'd8388352, 15'd0,
      1'b0, 1'b0},
    '{16'h0001, 32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'hFFFB, 32'd1, 1'b1, 16'd1, 15'd1, 15'd0, 15'd1, 23'd256, 15'd0, 1'b0, 1'b0},
    '{16'h0001, 32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'h7FFF, 32'd2, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'h8000, 32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'd500,  32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'd300,  32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'd400,  32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'd100,  32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'h0000, 32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    // run of repeated full-scale words
    '{16'h7FFF, 32'd3, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'h0000, 32'd1, 1'b1, 16'd3, 15'd32767, 15'd32767, 15'd32767, 23'd8388352,
      15'd0, 1'b0, 1'b0},
    '{16'h0000, 32'd1, 1'b1, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b1, 1'b0},
    '{16'h5555, 32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'h2AAA, 32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'h4000, 32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0},
    '{16'hAAAA, 32'd1, 1'b0, 16'd0, 15'd0, 15'd0, 15'd0, 23'd0, 15'd0, 1'b0, 1'b0}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [SAMPLE_BITS-1:0]   s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [M_TDATA_W-1:0]     m_tdata;
  logic [M_TUSER_W-1:0]     m_tuser;

  // run statistics as the block should hold them
  logic [31:0]           run_sum;
  int unsigned           run_count;
  logic [VALUE_BITS-1:0] run_max;
  logic [VALUE_BITS-1:0] run_max2;
  logic [VALUE_BITS-1:0] run_min;
  bit                    run_ovf;

  due_t        stats_due[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 1;

  running_sample_statistics_top #(
    .MAX_COUNT(MAX_SAMPLES)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic void clear_stats();
    run_sum = '0;
    run_count = 0;
    run_max = '0;
    run_max2 = '0;
    run_min = MIN_RESET;
    run_ovf = 1'b0;
  endfunction

  // folds one word into the run; returns 1 with the run result on a closing word
  function automatic bit accumulate_sample(input logic [15:0] s, output result_t r,
                                           output flags_t f);
    longint unsigned quotient;
    logic [VALUE_BITS-1:0] v;
    v = s[VALUE_BITS-1:0];
    r = '0;
    f = '0;
    if (!s[15] && s != 16'd0) begin
      if (run_count >= MAX_SAMPLES) begin
        run_ovf = 1'b1;
        return 1'b0;
      end
      run_sum = run_sum + 32'(v);
      if (run_max < v) begin
        run_max2 = run_max;
        run_max = v;
      end else if (run_max2 < v) begin
        run_max2 = v;
      end
      if (run_min > v) run_min = v;
      run_count++;
      return 1'b0;
    end
    f.empty_run = (run_count == 0);
    f.count_overflow = run_ovf;
    r.sample_count = 16'(run_count);
    if (run_count != 0) begin
      quotient = (64'(run_sum) << FRAC_BITS) / 64'(run_count);
      r.largest = run_max;
      r.second_largest = run_max2;
      r.smallest = run_min;
      r.mean_q8 = quotient[MEAN_BITS-1:0];
      r.spread = run_max - run_min;
    end
    clear_stats();
    return 1'b1;
  endfunction

  function automatic string describe_word(input due_t d);
    return $sformatf("cnt %0d max %0d 2nd %0d min %0d mean %0d spr %0d emp %0b ovf %0b pad %h",
                     d.stats.sample_count, d.stats.largest, d.stats.second_largest,
                     d.stats.smallest, d.stats.mean_q8, d.stats.spread,
                     d.flags.empty_run, d.flags.count_overflow, d.stats.pad);
  endfunction

  function automatic logic [15:0] positive_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 32767));
      1: return 16'($urandom_range(1, 16));
      2: return 16'($urandom_range(32700, 32767));
      default: return 16'(1 << $urandom_range(0, 14));
    endcase
  endfunction

  function automatic logic [15:0] closing_sample();
    if ($urandom_range(0, 2) == 0) return 16'h0000;
    return 16'(0 - int'($urandom_range(1, 32768)));
  endfunction

  task automatic send_word(input logic [15:0] s, input bit typed, input due_t typed_due);
    result_t     r;
    flags_t      f;
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata <= s;
    do @(posedge clk); while (!s_tready);
    if (accumulate_sample(s, r, f)) begin
      stats_due.push_back(typed ? typed_due : due_t'({f, r}));
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (stats_due.size() != 0);
    burst_left = 1;
  endtask

  // receiver pacing, with one long hold-off once results flow
  initial begin : sink_pacing
    pace_t       pace;
    int unsigned pace_left;
    bit          held_off;
    pace = PACE_OPEN;
    pace_left = 0;
    held_off = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held_off && results_seen >= 40) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (pace_left == 0) begin
          pace = pace_t'($urandom_range(0, 3));
          pace_left = $urandom_range(5, 80);
        end
        pace_left--;
        case (pace)
          PACE_OPEN:   m_tready <= 1'b1;
          PACE_COIN:   m_tready <= 1'($urandom_range(0, 1));
          PACE_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:     m_tready <= (pace_left % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    due_t want;
    due_t got;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got = due_t'({m_tuser, m_tdata});
      if (stats_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word %h", got);
      end else begin
        want = stats_due.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: exp %s / got %s", describe_word(want),
                     describe_word(got));
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("running_sample_statistics_top regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    due_t        typed_due;
    int unsigned words;
    int unsigned run_len;
    bit          paused;
    clear_stats();
    @(negedge rst);
    @(posedge clk);

    foreach (STIM_ROWS[i]) begin
      typed_due = '0;
      typed_due.stats.sample_count = STIM_ROWS[i].cnt;
      typed_due.stats.largest = STIM_ROWS[i].lg;
      typed_due.stats.second_largest = STIM_ROWS[i].sec;
      typed_due.stats.smallest = STIM_ROWS[i].sm;
      typed_due.stats.mean_q8 = STIM_ROWS[i].mean;
      typed_due.stats.spread = STIM_ROWS[i].spr;
      typed_due.flags.empty_run = STIM_ROWS[i].emp;
      typed_due.flags.count_overflow = STIM_ROWS[i].ovf;
      for (int unsigned k = 0; k < STIM_ROWS[i].reps; k++) begin
        send_word(STIM_ROWS[i].sample, STIM_ROWS[i].typed, typed_due);
      end
    end
    drain_results();

    words = 0;
    paused = 1'b0;
    while (words < RANDOM_WORDS) begin
      if (!paused && words >= RANDOM_WORDS / 2) begin
        paused = 1'b1;
        drain_results();
      end
      if ($urandom_range(0, 99) < 85) begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                              : $urandom_range(0, 12);
        repeat (run_len) begin
          send_word(positive_sample(), 1'b0, '0);
          words++;
        end
        send_word(closing_sample(), 1'b0, '0);
        words++;
      end else begin
        send_word(16'($urandom_range(0, 65535)), 1'b0, '0);
        words++;
      end
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("running_sample_statistics_top regression: pass");
    end else begin
      $display("running_sample_statistics_top regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rss_pkg.sv
rtl/core/rss_div.sv
rtl/core/running_sample_statistics_top.sv
rtl/core/rss_checker.sv
tb/tb_top.sv
